// ----- sv/dhc_pkg.sv -----
// Shared types and constants of the depth-to-hue colorizer.
package dhc_pkg;

	localparam int DEPTH_W         = 16;
	localparam int CHAN_W          = 8;
	localparam int FRAC_W          = 16;
	localparam int DIV_STEPS       = 20;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
	localparam int QUO_W           = DIV_STEPS;
	localparam int HUE_W           = QUO_W - 1;
	localparam int SECT_W          = HUE_W - FRAC_W;
	localparam int CFG_IDX_W       = 1;

	localparam logic [DEPTH_W-1:0] LOW_RESET  = 16'd500;
	localparam logic [DEPTH_W-1:0] HIGH_RESET = 16'd5800;
	localparam logic [CHAN_W-1:0]  CHAN_FULL  = 8'd255;
	localparam logic [CHAN_W-1:0]  CHAN_EMPTY = 8'd0;
	localparam logic [HUE_W-1:0]   HUE_MAX    = 19'h40000;

	localparam logic [SECT_W-1:0] SECT_RED_GREEN  = 3'd0;
	localparam logic [SECT_W-1:0] SECT_GREEN_RED  = 3'd1;
	localparam logic [SECT_W-1:0] SECT_GREEN_BLUE = 3'd2;
	localparam logic [SECT_W-1:0] SECT_BLUE_GREEN = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_LIMIT  = 1'b0,
		REG_HIGH_LIMIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               last;
		logic               zero;
		logic               unordered;
		logic               nbit;
		logic [DEPTH_W-1:0] rem;
		logic [DEPTH_W-1:0] dvsr;
		logic [QUO_W-1:0]   quo;
	} div_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} pixel_t;

endpackage

// ----- sv/dhc_if.sv -----
// Request channels of the colorizer: depth samples in, pixels out.
interface dhc_sample_if
	import dhc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_sample;
	logic               last_in_frame;

	modport source(output valid, depth_sample, last_in_frame, input ready);
	modport sink(input valid, depth_sample, last_in_frame, output ready);
endinterface

interface dhc_pixel_if
	import dhc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              last_out;

	modport source(output valid, red, green, blue, last_out, input ready);
	modport sink(input valid, red, green, blue, last_out, output ready);
endinterface

// ----- sv/dhc_front.sv -----
// Input stage: clamp the sample and set up the divider operands.
module dhc_front
	import dhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DEPTH_W-1:0] depth,
	input  logic               last,
	input  logic [DEPTH_W-1:0] low_limit,
	input  logic [DEPTH_W-1:0] high_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output div_word_t          out_word
);

	logic               valid_s1;
	div_word_t          word_s1;
	div_word_t          word_d;
	logic [DEPTH_W-1:0] clamp;
	logic [DEPTH_W-1:0] numer;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_comb begin
		clamp = (depth > high_limit) ? high_limit : depth;
		clamp = (clamp < low_limit) ? low_limit : clamp;
		numer = high_limit - clamp;
		word_d.last      = last;
		word_d.zero      = (depth == '0);
		word_d.unordered = (low_limit >= high_limit);
		word_d.nbit      = numer[0];
		word_d.rem       = {1'b0, numer[DEPTH_W-1:1]};
		word_d.dvsr      = high_limit - low_limit;
		word_d.quo       = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

endmodule

// ----- sv/dhc_div_stage.sv -----
// One divider stage: a few restoring compare-and-subtract steps.
module dhc_div_stage
	import dhc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic      valid_s1;
	div_word_t word_s1;
	div_word_t word_d;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_comb begin
		logic [DEPTH_W:0] trial;
		logic             qbit;
		word_d = in_word;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			trial       = {word_d.rem, word_d.nbit};
			qbit        = (trial >= {1'b0, word_d.dvsr});
			if (qbit) begin
				trial = trial - {1'b0, word_d.dvsr};
			end
			word_d.rem  = trial[DEPTH_W-1:0];
			word_d.nbit = 1'b0;
			word_d.quo  = {word_d.quo[QUO_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

endmodule

// ----- sv/dhc_color.sv -----
// Output stage: map the hue to a four-sector RGB pixel.
module dhc_color
	import dhc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output pixel_t    out_pix
);

	logic                valid_s1;
	pixel_t              pix_s1;
	pixel_t              pix_d;
	logic [HUE_W-1:0]    hue;
	logic [SECT_W-1:0]   sector;
	logic [FRAC_W-1:0]   frac;
	logic [FRAC_W:0]     frac_inv;
	logic [FRAC_W+7:0]   rise_prod;
	logic [FRAC_W+8:0]   fall_prod;
	logic [CHAN_W-1:0]   rise;
	logic [CHAN_W-1:0]   fall;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_pix   = pix_s1;

	assign hue       = in_word.quo[QUO_W-1:1];
	assign sector    = hue[HUE_W-1:FRAC_W];
	assign frac      = hue[FRAC_W-1:0];
	assign frac_inv  = {1'b1, {FRAC_W{1'b0}}} - {1'b0, frac};
	assign rise_prod = {frac, 8'd0} - {8'd0, frac};
	assign fall_prod = {frac_inv, 8'd0} - {8'd0, frac_inv};
	assign rise      = rise_prod[FRAC_W+7:FRAC_W];
	assign fall      = fall_prod[FRAC_W+7:FRAC_W];

	always_comb begin
		pix_d.last = in_word.last;
		unique case (sector)
			SECT_RED_GREEN: begin
				pix_d.red = CHAN_FULL; pix_d.green = rise; pix_d.blue = CHAN_EMPTY;
			end
			SECT_GREEN_RED: begin
				pix_d.red = fall; pix_d.green = CHAN_FULL; pix_d.blue = CHAN_EMPTY;
			end
			SECT_GREEN_BLUE: begin
				pix_d.red = CHAN_EMPTY; pix_d.green = CHAN_FULL; pix_d.blue = rise;
			end
			SECT_BLUE_GREEN: begin
				pix_d.red = CHAN_EMPTY; pix_d.green = fall; pix_d.blue = CHAN_FULL;
			end
			default: begin
				pix_d.red = rise; pix_d.green = CHAN_EMPTY; pix_d.blue = CHAN_FULL;
			end
		endcase
		if (in_word.zero) begin
			pix_d.red   = CHAN_EMPTY;
			pix_d.green = CHAN_EMPTY;
			pix_d.blue  = CHAN_EMPTY;
		end else if (in_word.unordered) begin
			pix_d.red   = CHAN_EMPTY;
			pix_d.green = CHAN_EMPTY;
			pix_d.blue  = CHAN_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_s1 <= pix_d;
		end
	end

endmodule

// ----- sv/depth_to_hue_colorizer.sv -----
// Top level of the depth-to-hue colorizer: limits, pipeline and checks.
//
//   channel  | dir | payload                          | handshake
//   sample   | in  | depth_sample[15:0], last_in_frame | valid/ready
//   pixel    | out | red, green, blue [7:0], last_out  | valid/ready
//   cfg      | in  | cfg_index[0], cfg_data[15:0]     | cfg_we
//
// One request per clock while the pixel sink takes pixels; the pipeline is a clamp stage, five divider
// stages of four quotient bits each, and a color stage with output register.
// Every stage holds its own valid bit and advances when it is empty or the
// next stage takes its word, so bubbles close up under a stall.
// Reset clears the valid bits and loads the limits with 500 and 5800.
module depth_to_hue_colorizer
	import dhc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	dhc_sample_if.sink           sample,
	dhc_pixel_if.source          pixel,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DEPTH_W-1:0]   cfg_data
);

	logic [DEPTH_W-1:0] low_q;
	logic [DEPTH_W-1:0] high_q;
	logic               div_valid [DIV_STAGES+1];
	logic               div_ready [DIV_STAGES+1];
	div_word_t          div_word  [DIV_STAGES+1];
	pixel_t             pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_LIMIT:  low_q  <= cfg_data;
				REG_HIGH_LIMIT: high_q <= cfg_data;
			endcase
		end
	end

	dhc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample.valid),
		.in_ready   (sample.ready),
		.depth      (sample.depth_sample),
		.last       (sample.last_in_frame),
		.low_limit  (low_q),
		.high_limit (high_q),
		.out_valid  (div_valid[0]),
		.out_ready  (div_ready[0]),
		.out_word   (div_word[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		dhc_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[k]),
			.in_ready  (div_ready[k]),
			.in_word   (div_word[k]),
			.out_valid (div_valid[k+1]),
			.out_ready (div_ready[k+1]),
			.out_word  (div_word[k+1])
		);
	end

	dhc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[DIV_STAGES]),
		.in_ready  (div_ready[DIV_STAGES]),
		.in_word   (div_word[DIV_STAGES]),
		.out_valid (pixel.valid),
		.out_ready (pixel.ready),
		.out_pix   (pix)
	);

	assign pixel.red      = pix.red;
	assign pixel.green    = pix.green;
	assign pixel.blue     = pix.blue;
	assign pixel.last_out = pix.last;

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready |-> sample.ready)
		else $error("input stalled while output is taken");

	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.valid |-> sample.ready)
		else $error("input stalled with an empty output stage");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid[DIV_STAGES] && !div_word[DIV_STAGES].unordered)
		|-> (div_word[DIV_STAGES].quo[QUO_W-1:1] <= HUE_MAX))
		else $error("hue beyond four sectors");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid |-> (pixel.red == CHAN_FULL || pixel.green == CHAN_FULL ||
			pixel.blue == CHAN_FULL ||
			(pixel.red == CHAN_EMPTY && pixel.green == CHAN_EMPTY &&
			pixel.blue == CHAN_EMPTY)))
		else $error("pixel is neither saturated nor black");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the depth-to-hue colorizer with its own pixel predictor.
`timescale 1ns / 1ps

module testbench
	import dhc_pkg::*;
;

	localparam int PIPE_LATENCY = 7;
	localparam int CYCLE_LIMIT  = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DEPTH_W-1:0]   cfg_data;

	dhc_sample_if sample_ch();
	dhc_pixel_if  pixel_ch();

	depth_to_hue_colorizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.pixel     (pixel_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [DEPTH_W-1:0] low_limit;
	logic [DEPTH_W-1:0] high_limit;
	pixel_t             expected_pixels[$];
	int unsigned        src_idle_pct;
	int unsigned        snk_idle_pct;
	int unsigned        samples_sent;
	int unsigned        pixels_checked;
	int unsigned        pixel_errors;
	int unsigned        settings_used;
	int unsigned        cycle_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
				expected_pixels.size());
			$display("depth_to_hue_colorizer regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		pixel_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic logic [CHAN_W-1:0] ramp_up(input logic [FRAC_W-1:0] f);
		logic [31:0] prod;
		prod = {16'd0, f} * 32'd255;
		return prod[23:16];
	endfunction

	function automatic logic [CHAN_W-1:0] ramp_down(input logic [FRAC_W-1:0] f);
		logic [31:0] prod;
		prod = (32'h10000 - {16'd0, f}) * 32'd255;
		return prod[23:16];
	endfunction

	function automatic pixel_t hue_of(input logic [DEPTH_W-1:0] d, input logic l);
		pixel_t             p;
		logic [DEPTH_W-1:0] c;
		logic [63:0]        x;
		logic [SECT_W-1:0]  sect;
		logic [FRAC_W-1:0]  f;
		p       = '0;
		p.last  = l;
		if (d != '0) begin
			if (low_limit >= high_limit) begin
				p.blue = CHAN_FULL;
			end else begin
				c = d;
				if (c > high_limit)
					c = high_limit;
				if (c < low_limit)
					c = low_limit;
				x    = ({48'd0, high_limit - c} << 18) / {48'd0, high_limit - low_limit};
				sect = x[18:16];
				f    = x[15:0];
				case (sect)
					SECT_RED_GREEN: begin
						p.red   = CHAN_FULL;
						p.green = ramp_up(f);
						p.blue  = CHAN_EMPTY;
					end
					SECT_GREEN_RED: begin
						p.red   = ramp_down(f);
						p.green = CHAN_FULL;
						p.blue  = CHAN_EMPTY;
					end
					SECT_GREEN_BLUE: begin
						p.red   = CHAN_EMPTY;
						p.green = CHAN_FULL;
						p.blue  = ramp_up(f);
					end
					SECT_BLUE_GREEN: begin
						p.red   = CHAN_EMPTY;
						p.green = ramp_down(f);
						p.blue  = CHAN_FULL;
					end
					default: begin
						p.red   = ramp_up(f);
						p.green = CHAN_EMPTY;
						p.blue  = CHAN_FULL;
					end
				endcase
			end
		end
		return p;
	endfunction

	always @(negedge clk) begin
		pixel_t want;
		pixel_t got;
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			got.red   = pixel_ch.red;
			got.green = pixel_ch.green;
			got.blue  = pixel_ch.blue;
			got.last  = pixel_ch.last_out;
			if (expected_pixels.size() == 0) begin
				if (pixel_errors < 10)
					$display("pixel %0d with no request pending: r%0d g%0d b%0d last%0d",
						pixels_checked, got.red, got.green, got.blue, got.last);
				pixel_errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue || got.last !== want.last) begin
					if (pixel_errors < 10)
						$display("pixel %0d mismatch: expected r%0d g%0d b%0d last%0d",
							pixels_checked, want.red, want.green, want.blue,
							want.last, ", got r%0d g%0d b%0d last%0d",
							got.red, got.green, got.blue, got.last);
					pixel_errors++;
				end
			end
			pixels_checked++;
		end
	end

	task automatic drain_pixels();
		sample_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_pixels.size() != 0);
	endtask

	task automatic set_limits(input logic [DEPTH_W-1:0] lo, input logic [DEPTH_W-1:0] hi);
		drain_pixels();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOW_LIMIT;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_HIGH_LIMIT;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we     <= 1'b0;
		low_limit  = lo;
		high_limit = hi;
		settings_used++;
	endtask

	task automatic send_depth(input logic [DEPTH_W-1:0] d, input logic l);
		logic taken;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.depth_sample  <= d;
		sample_ch.last_in_frame <= l;
		do begin
			@(negedge clk);
			taken = sample_ch.ready;
			@(posedge clk);
		end while (!taken);
		expected_pixels.push_back(hue_of(d, l));
		samples_sent++;
	endtask

	function automatic logic [DEPTH_W-1:0] pick_depth();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 22)
			return DEPTH_W'($urandom_range(16'hFFFF));
		if (roll < 28) begin
			case ($urandom_range(3))
				0:       return 16'd1;
				1:       return 16'hFFFF;
				2:       return low_limit;
				default: return high_limit;
			endcase
		end
		if (low_limit < high_limit)
			return DEPTH_W'($urandom_range(high_limit, low_limit));
		return DEPTH_W'($urandom_range(16'hFFFF));
	endfunction

	task automatic pick_limits();
		logic [DEPTH_W-1:0] lo;
		logic [DEPTH_W-1:0] hi;
		case ($urandom_range(5))
			0: set_limits(LOW_RESET, HIGH_RESET);
			1: set_limits(16'd0, 16'hFFFF);
			2: begin
				lo = DEPTH_W'($urandom_range(65000));
				set_limits(lo, lo + DEPTH_W'($urandom_range(20, 1)));
			end
			3: begin
				lo = DEPTH_W'($urandom_range(30000));
				set_limits(lo, DEPTH_W'($urandom_range(16'hFFFF, lo + 1)));
			end
			4: begin
				lo = DEPTH_W'($urandom_range(16'hFFFF, 1));
				set_limits(lo, DEPTH_W'($urandom_range(lo)));
			end
			default: begin
				lo = DEPTH_W'($urandom_range(16'hFFFF));
				hi = DEPTH_W'($urandom_range(16'hFFFF));
				if (lo <= hi)
					set_limits(lo, hi);
				else
					set_limits(hi, lo);
			end
		endcase
	endtask

	task automatic test_reset_limits();
		send_depth(16'd0, 1'b0);
		send_depth(16'd1, 1'b1);
		send_depth(16'd499, 1'b0);
		send_depth(16'd500, 1'b0);
		send_depth(16'd501, 1'b1);
		send_depth(16'd1825, 1'b0);
		send_depth(16'd3150, 1'b0);
		send_depth(16'd4474, 1'b1);
		send_depth(16'd4475, 1'b0);
		send_depth(16'd5799, 1'b0);
		send_depth(16'd5800, 1'b1);
		send_depth(16'd5801, 1'b0);
		send_depth(16'hFFFF, 1'b1);
	endtask

	task automatic test_extreme_limits();
		set_limits(16'd0, 16'hFFFF);
		send_depth(16'd1, 1'b0);
		send_depth(16'h8000, 1'b1);
		send_depth(16'hFFFF, 1'b0);
		set_limits(16'd0, 16'd1);
		send_depth(16'd1, 1'b1);
		send_depth(16'd2, 1'b0);
		set_limits(16'hFFFE, 16'hFFFF);
		send_depth(16'hFFFF, 1'b0);
		send_depth(16'd1, 1'b1);
	endtask

	task automatic test_unordered_limits();
		set_limits(16'd1000, 16'd1000);
		send_depth(16'd1000, 1'b0);
		send_depth(16'd0, 1'b1);
		send_depth(16'd7, 1'b0);
		set_limits(16'hFFFF, 16'd0);
		send_depth(16'hFFFF, 1'b1);
		send_depth(16'd0, 1'b0);
	endtask

	task automatic test_random_stream(input int unsigned n, input int unsigned snd_pct,
		input int unsigned rcv_pct);
		src_idle_pct = snd_pct;
		snk_idle_pct = rcv_pct;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 45 == 0)
				pick_limits();
			else if (i % 45 == 22 && $urandom_range(1))
				drain_pixels();
			send_depth(pick_depth(), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_LOW_LIMIT;
		cfg_data                = '0;
		sample_ch.valid         = 1'b0;
		sample_ch.depth_sample  = '0;
		sample_ch.last_in_frame = 1'b0;
		pixel_ch.ready          = 1'b0;
		low_limit               = LOW_RESET;
		high_limit              = HIGH_RESET;
		src_idle_pct            = 26;
		snk_idle_pct            = 52;
		samples_sent            = 0;
		pixels_checked          = 0;
		pixel_errors            = 0;
		settings_used           = 0;
		cycle_count             = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limits();
		test_extreme_limits();
		test_unordered_limits();
		test_random_stream(180, 26, 52);
		test_random_stream(180, 52, 26);
		test_random_stream(190, 0, 0);

		drain_pixels();
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		$display("sent %0d depth samples, checked %0d pixels", samples_sent, pixels_checked);
		$display("limit settings applied: %0d, mismatches: %0d", settings_used, pixel_errors);
		if (pixel_errors == 0 && expected_pixels.size() == 0) begin
			$display("depth_to_hue_colorizer regression: pass");
		end else begin
			$display("depth_to_hue_colorizer regression: fail");
		end
		$finish;
	end

endmodule
